@@ hdl/rmt_pkg.sv @@
// Shared types for the running median tracker: controller commands and datapath status.
`timescale 1ns / 1ps

package rmt_pkg;

    typedef enum logic [1:0] {
        RD_TOP  = 2'd0,
        RD_DOWN = 2'd1,
        RD_LO   = 2'd2,
        RD_HI   = 2'd3
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_MOVE   = 2'd1,
        WR_PLACE  = 2'd2,
        WR_BOTTOM = 2'd3
    } wr_sel_t;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    latch_a;
        logic    load_out;
    } rmt_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic rdata_gt;
        logic idx_zero;
    } rmt_status_t;

endpackage

@@ hdl/rmt_datapath.sv @@
// Datapath of the running median tracker: sorted sample memory, count, median adder, output.
`timescale 1ns / 1ps

module rmt_datapath
    import rmt_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rmt_cmd_t           cmd,
    output rmt_status_t        status,
    input  logic        [31:0] sample_in,
    output logic        [32:0] median_out,
    output logic        [10:0] count_out,
    output logic               dropped_out
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;
    logic [31:0]   sample_reg;
    logic [31:0]   a_reg;
    logic          dropped_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;

    logic [32:0]   median_reg;
    logic [10:0]   count_out_reg;
    logic          dropped_out_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          wr_en;
    logic [CW-1:0] count_m1;
    logic [CW-1:0] lo_cnt;
    logic [CW-1:0] hi_cnt;
    logic [CW+10:0] count_wide;
    logic [32:0]   sum;

    assign count_m1   = count_reg - CW'(1);
    assign lo_cnt     = count_m1 >> 1;
    assign hi_cnt     = count_reg >> 1;
    assign count_wide = {11'd0, count_reg};
    assign sum        = {a_reg[31], a_reg} + {rdata_reg[31], rdata_reg};

    always_comb begin
        unique case (cmd.rd_sel)
            RD_TOP:  rd_addr = count_m1[AW-1:0];
            RD_DOWN: rd_addr = idx_reg - AW'(1);
            RD_LO:   rd_addr = lo_cnt[AW-1:0];
            RD_HI:   rd_addr = hi_cnt[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = idx_reg + AW'(1);
        wr_data = sample_reg;
        unique case (cmd.wr_sel)
            WR_NONE:   wr_en = 1'b0;
            WR_MOVE:   wr_data = rdata_reg;
            WR_PLACE:  wr_data = sample_reg;
            WR_BOTTOM: wr_addr = '0;
            default:   wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg  <= sample_in;
            dropped_reg <= status.count_full;
        end
        if (cmd.rd_en && cmd.rd_sel == RD_TOP) begin
            idx_reg <= count_m1[AW-1:0];
        end else if (cmd.rd_en && cmd.rd_sel == RD_DOWN) begin
            idx_reg <= idx_reg - AW'(1);
        end
        if (cmd.latch_a) begin
            a_reg <= rdata_reg;
        end
        if (cmd.load_out) begin
            median_reg      <= sum;
            count_out_reg   <= count_wide[10:0];
            dropped_out_reg <= dropped_reg;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == CAP_CNT);
    assign status.rdata_gt   = ($signed(rdata_reg) > $signed(sample_reg));
    assign status.idx_zero   = (idx_reg == '0);

    assign median_out  = median_reg;
    assign count_out   = count_out_reg;
    assign dropped_out = dropped_out_reg;

endmodule

@@ hdl/rmt_ctrl.sv @@
// Controller of the running median tracker: request handshake and insert/median sequencing.
`timescale 1ns / 1ps

module rmt_ctrl
    import rmt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  rmt_status_t status,
    output rmt_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SHIFT  = 6'b000010,
        ST_BOTTOM = 6'b000100,
        ST_MED_LO = 6'b001000,
        ST_MED_HI = 6'b010000,
        ST_SUM    = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_TOP;
        cmd.wr_sel   = WR_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    priority if (status.count_full) begin
                        state_next = ST_MED_LO;
                    end else if (status.count_zero) begin
                        state_next = ST_BOTTOM;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_TOP;
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (status.rdata_gt) begin
                    cmd.wr_sel = WR_MOVE;
                    if (status.idx_zero) begin
                        state_next = ST_BOTTOM;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_DOWN;
                    end
                end else begin
                    cmd.wr_sel  = WR_PLACE;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_MED_LO;
                end
            end
            ST_BOTTOM: begin
                cmd.wr_sel  = WR_BOTTOM;
                cmd.cnt_inc = 1'b1;
                state_next  = ST_MED_LO;
            end
            ST_MED_LO: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LO;
                state_next = ST_MED_HI;
            end
            ST_MED_HI: begin
                cmd.latch_a = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_HI;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in progress");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("output overwritten while result pending");

    a_place_ends_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT && !status.rdata_gt) |=> (state_reg == ST_MED_LO))
        else $error("insert did not finish after placing the sample");

    a_full_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_tvalid && status.count_full) |=>
        (state_reg == ST_MED_LO && cmd.wr_sel == WR_NONE && !cmd.cnt_inc))
        else $error("full store modified by dropped sample");

endmodule

@@ hdl/running_median_tracker.sv @@
// Top level of the running median tracker: sorted-store insert with doubled median output.
// Sequence: a dropped sample goes straight to the two median reads; an insert into a store
//   shifts each larger entry up one entry per cycle through the sample memory (one read and
//   one write a cycle), places the sample, then does two median reads before the result is loaded.
// Throughput: one request at a time; the next request is taken once the result is loaded.
// Reset: aresetn clears the count and the handshake state; memory contents are not cleared.
`timescale 1ns / 1ps

module running_median_tracker
    import rmt_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [32:0] median_doubled, [43:33] stored_count, zero fill
    output logic        m_tuser    // [0] dropped_full
);

    rmt_cmd_t    cmd;
    rmt_status_t status;
    logic [32:0] median;
    logic [10:0] count;

    rmt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rmt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .sample_in   (s_tdata),
        .median_out  (median),
        .count_out   (count),
        .dropped_out (m_tuser)
    );

    assign m_tdata = {4'd0, count, median};

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for running_median_tracker: directed, burst, backpressure and fill tests.
`timescale 1ns / 1ps

module testbench;

    localparam int          CAPACITY        = 1024;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          DRAIN_CYCLES    = 40;
    localparam int unsigned CYCLE_LIMIT     = 8_000_000;
    localparam int          IDLE_PCT        = 37;

    typedef struct {
        logic signed [32:0] median_doubled;
        logic [10:0]        stored_count;
        logic               dropped_full;
    } median_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        m_tuser;

    logic signed [31:0] ordered_samples[$];
    median_result_t     pending_medians[$];
    int unsigned        mismatch_count;
    int unsigned        tx_idle_pct;
    int unsigned        rx_idle_pct;
    logic               hold_off_pending;

    running_median_tracker #(.CAPACITY(CAPACITY)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("%0t: timeout after %0d cycles", $time, cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic void track_sample(input logic signed [31:0] sample);
        median_result_t     res;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        int                 pos;
        int                 n;
        res.dropped_full = (ordered_samples.size() >= CAPACITY);
        if (!res.dropped_full) begin
            pos = 0;
            while (pos < ordered_samples.size() && ordered_samples[pos] <= sample)
                pos++;
            ordered_samples.insert(pos, sample);
        end
        n = ordered_samples.size();
        lo = ordered_samples[(n - 1) / 2];
        hi = ordered_samples[n / 2];
        res.median_doubled = $signed({lo[31], lo}) + $signed({hi[31], hi});
        res.stored_count = 11'(n);
        pending_medians.push_back(res);
    endfunction

    function automatic void check_result(input logic [47:0] data, input logic user);
        median_result_t exp_res;
        if (pending_medians.size() == 0) begin
            $display("%0t: result with no request pending: data %h user %b", $time, data, user);
            mismatch_count++;
            return;
        end
        exp_res = pending_medians.pop_front();
        if (data[32:0] !== exp_res.median_doubled) begin
            $display("%0t: median_doubled expected %0d, actual %0d", $time,
                     exp_res.median_doubled, $signed(data[32:0]));
            mismatch_count++;
        end
        if (data[43:33] !== exp_res.stored_count) begin
            $display("%0t: stored_count expected %0d, actual %0d", $time,
                     exp_res.stored_count, data[43:33]);
            mismatch_count++;
        end
        if (user !== exp_res.dropped_full) begin
            $display("%0t: dropped_full expected %b, actual %b", $time,
                     exp_res.dropped_full, user);
            mismatch_count++;
        end
    endfunction

    initial begin : result_monitor
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_result(m_tdata, m_tuser);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_sample(input logic signed [31:0] sample);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        track_sample(sample);
    endtask

    function automatic logic signed [31:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom();
        if (pick < 80)
            return int'($urandom_range(0, 15)) - 8;
        if (pick < 85)
            return 32'sh7FFF_FFFF - int'($urandom_range(0, 3));
        if (pick < 90)
            return 32'sh8000_0000 + int'($urandom_range(0, 3));
        if (ordered_samples.size() == 0)
            return $urandom();
        return ordered_samples[$urandom_range(0, ordered_samples.size() - 1)];
    endfunction

    task automatic test_extremes();
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        repeat (4) send_sample(32'sh8000_0000);
        send_sample(32'sh0000_0000);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sh5555_5555);
        send_sample(32'shAAAA_AAAA);
    endtask

    task automatic test_equal_values();
        repeat (4) send_sample(32'sd5);
        send_sample(32'sd4);
        send_sample(32'sd6);
        send_sample(32'sd5);
    endtask

    task automatic test_no_idle_burst();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (80) send_sample(random_sample());
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_backpressure();
        hold_off_pending = 1'b1;
        repeat (20) send_sample(random_sample());
    endtask

    task automatic test_random_fill();
        while (ordered_samples.size() < CAPACITY)
            send_sample(random_sample());
    endtask

    task automatic test_store_full();
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh0000_0000);
        repeat (27) send_sample(random_sample());
    endtask

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        mismatch_count   = 0;
        tx_idle_pct      = IDLE_PCT;
        rx_idle_pct      = IDLE_PCT;
        hold_off_pending = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_equal_values();
        test_no_idle_burst();
        test_backpressure();
        test_random_fill();
        test_store_full();

        s_tvalid <= 1'b0;
        while (pending_medians.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
